### design/swts_pkg.sv
package swts_pkg;

  // Fixed field widths of the channels.
  localparam int ELEM_W  = 32;
  localparam int START_W = 11;
  localparam int END_W   = 10;

  // Default depth of the window buffer.
  localparam int MAX_LENGTH_DEF = 1024;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the request on the input channel
    logic rd_issue;   // read the oldest window entry
    logic pop;        // remove the oldest entry from the sum
    logic set_match;  // capture a found result
    logic set_none;   // capture a not-found result
    logic clear_seq;  // end of sequence: reset the window state
    logic load_out;   // move the pending result to the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_push;   // sequence still open and buffer not full
    logic shrink;     // sum above target with a non-empty window
    logic equal;      // sum equals target
    logic in_last;    // last flag of the request on the input channel
    logic last;       // last flag of the request being worked on
    logic matched;    // a match was reported in this sequence
    logic out_free;   // output register can take a result
  } status_t;

endpackage

### design/swts_ifs.sv
// Input channel: one element per request.
interface swts_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [swts_pkg::ELEM_W-1:0] element;
  logic                              last;

  modport source (output valid, output element, output last, input ready);
  modport sink   (input valid, input element, input last, output ready);
endinterface

// Result channel.
interface swts_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [swts_pkg::START_W-1:0] start_index;
  logic [swts_pkg::END_W-1:0]   end_index;

  modport source (output valid, output found, output start_index, output end_index,
                  input ready);
  modport sink   (input valid, input found, input start_index, input end_index,
                  output ready);
endinterface

// Configuration write channel for the target register.
interface swts_cfg_if;
  logic                              valid;
  logic                              ready;
  logic signed [swts_pkg::ELEM_W-1:0] target_sum;

  modport source (output valid, output target_sum, input ready);
  modport sink   (input valid, input target_sum, output ready);
endinterface

### design/subarray_with_target_sum_core.sv
// An element is taken in IDLE and, if pushed, checked in CHECK; while the sum is
// above target with a non-empty window, CHECK reads the oldest entry and POP
// removes it. A result goes through EMIT to the output register. One element is
// worked on at a time; the pop loop uses the buffer's single registered read port.
// Reset (rst_n, synchronous, active low) clears the target, the window state and
// the output valid; the window buffer itself is not cleared.
module subarray_with_target_sum_core #(
  parameter int MAX_LENGTH = swts_pkg::MAX_LENGTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  swts_in_if.sink     in_if,
  swts_out_if.source  out_if,
  swts_cfg_if.sink    cfg_if
);

  swts_pkg::cmd_t    cmd;
  swts_pkg::status_t st;

  // The target register takes a write in any cycle.
  assign cfg_if.ready = 1'b1;

  swts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  swts_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_element      (in_if.element),
    .in_last         (in_if.last),
    .cfg_valid       (cfg_if.valid),
    .cfg_target_sum  (cfg_if.target_sum),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_found       (out_if.found),
    .out_start_index (out_if.start_index),
    .out_end_index   (out_if.end_index),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

### design/swts_ctrl.sv
module swts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swts_pkg::status_t st,
  output swts_pkg::cmd_t    cmd
);

  swts_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      swts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.can_push) begin
            state_nxt = swts_pkg::ST_CHECK;
          end else if (st.in_last) begin
            // Ignored element that closes the sequence.
            cmd.clear_seq = 1'b1;
            if (!st.matched) begin
              cmd.set_none = 1'b1;
              state_nxt    = swts_pkg::ST_EMIT;
            end
          end
        end
      end
      swts_pkg::ST_CHECK: begin
        if (st.shrink) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = swts_pkg::ST_POP;
        end else if (st.equal) begin
          cmd.set_match = 1'b1;
          cmd.clear_seq = st.last;
          state_nxt     = swts_pkg::ST_EMIT;
        end else if (st.last) begin
          cmd.set_none  = 1'b1;
          cmd.clear_seq = 1'b1;
          state_nxt     = swts_pkg::ST_EMIT;
        end else begin
          state_nxt = swts_pkg::ST_IDLE;
        end
      end
      swts_pkg::ST_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = swts_pkg::ST_CHECK;
      end
      swts_pkg::ST_EMIT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = swts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### design/swts_dp.sv
module swts_dp #(
  parameter int MAX_LENGTH = swts_pkg::MAX_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [swts_pkg::ELEM_W-1:0] in_element,
  input  logic                               in_last,
  input  logic                               cfg_valid,
  input  logic signed [swts_pkg::ELEM_W-1:0] cfg_target_sum,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [swts_pkg::START_W-1:0]       out_start_index,
  output logic [swts_pkg::END_W-1:0]         out_end_index,
  input  swts_pkg::cmd_t                     cmd,
  output swts_pkg::status_t                  st
);

  localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
  localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int SUM_W  = swts_pkg::ELEM_W + CNT_W;

  // Window buffer.
  logic signed [swts_pkg::ELEM_W-1:0] mem [MAX_LENGTH];
  logic signed [swts_pkg::ELEM_W-1:0] rd_data_r;

  logic signed [swts_pkg::ELEM_W-1:0] target_r;
  logic signed [SUM_W-1:0]            sum_r;
  logic [CNT_W-1:0]                   start_r;
  logic [CNT_W-1:0]                   count_r;
  logic [ADDR_W-1:0]                  end_r;
  logic                               matched_r;
  logic                               last_r;

  logic                               res_found_r;
  logic [swts_pkg::START_W-1:0]       res_start_r;
  logic [swts_pkg::END_W-1:0]         res_end_r;

  logic                               out_valid_r;
  logic                               out_found_r;
  logic [swts_pkg::START_W-1:0]       out_start_r;
  logic [swts_pkg::END_W-1:0]         out_end_r;

  logic                               push;
  logic signed [SUM_W-1:0]            target_ext;

  assign push       = cmd.accept && st.can_push;
  assign target_ext = SUM_W'(target_r);

  // Status toward the controller.
  assign st.can_push = !matched_r && (count_r < CNT_W'(MAX_LENGTH));
  assign st.shrink   = (sum_r > target_ext) && (start_r <= CNT_W'(end_r));
  assign st.equal    = (sum_r == target_ext);
  assign st.in_last  = in_last;
  assign st.last     = last_r;
  assign st.matched  = matched_r;
  assign st.out_free = !out_valid_r || out_ready;

  // Buffer write on push and registered read of the oldest entry.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[count_r[ADDR_W-1:0]] <= in_element;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[start_r[ADDR_W-1:0]];
    end
  end

  // Target register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_valid) begin
      target_r <= cfg_target_sum;
    end
  end

  // Window state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      start_r   <= '0;
      count_r   <= '0;
      matched_r <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        last_r <= in_last;
      end
      if (cmd.clear_seq) begin
        sum_r     <= '0;
        start_r   <= '0;
        count_r   <= '0;
        matched_r <= 1'b0;
      end else begin
        if (push) begin
          sum_r   <= sum_r + SUM_W'(in_element);
          count_r <= count_r + 1'b1;
        end else if (cmd.pop) begin
          sum_r   <= sum_r - SUM_W'(rd_data_r);
          start_r <= start_r + 1'b1;
        end
        if (cmd.set_match) begin
          matched_r <= 1'b1;
        end
      end
    end
  end

  // Index of the newest element.
  always_ff @(posedge clk) begin
    if (push) begin
      end_r <= count_r[ADDR_W-1:0];
    end
  end

  // Pending result.
  always_ff @(posedge clk) begin
    if (cmd.set_match) begin
      res_found_r <= 1'b1;
      res_start_r <= swts_pkg::START_W'(start_r);
      res_end_r   <= swts_pkg::END_W'(end_r);
    end else if (cmd.set_none) begin
      res_found_r <= 1'b0;
      res_start_r <= '0;
      res_end_r   <= '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found_r <= res_found_r;
      out_start_r <= res_start_r;
      out_end_r   <= res_end_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_start_index = out_start_r;
  assign out_end_index   = out_end_r;

endmodule

### dv/swts_search_checker.sv
`timescale 1ns / 100ps

// Watches the element, result and target channels of the sliding-window search,
// keeps its own copy of the window and compares every result with the oldest
// predicted one.
module swts_search_checker #(
  parameter int MAX_LENGTH = swts_pkg::MAX_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [swts_pkg::ELEM_W-1:0]  in_element,
  input  logic                                in_last,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_found,
  input  logic [swts_pkg::START_W-1:0]        out_start_index,
  input  logic [swts_pkg::END_W-1:0]          out_end_index,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic signed [swts_pkg::ELEM_W-1:0]  cfg_target_sum,
  output int                                  pending,
  output int                                  fail_count
);
  import swts_pkg::*;

  localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start_index;
    logic [END_W-1:0]   end_index;
  } search_result_t;

  // Window state of the sequence in progress.
  logic signed [ELEM_W-1:0] window_mem [MAX_LENGTH];
  logic signed [41:0]       win_sum;
  logic [START_W-1:0]       win_head;
  logic [START_W-1:0]       seq_len;
  logic                     seq_matched;
  logic signed [ELEM_W-1:0] target_q;

  search_result_t predicted_results [$];
  int mismatches = 0;

  // Takes one element request and queues the result it causes, if any.
  function automatic void advance_window(input logic signed [ELEM_W-1:0] elem,
                                         input logic is_last);
    logic [START_W-1:0] end_idx;
    search_result_t     res;
    if (!seq_matched && seq_len < MAX_LENGTH) begin
      end_idx = seq_len;
      window_mem[end_idx[IDX_W-1:0]] = elem;
      win_sum = win_sum + 42'(elem);
      seq_len = seq_len + 1'b1;
      // Drop the oldest elements while the window sum overshoots the target.
      while (win_sum > 42'(target_q) && win_head <= end_idx && win_head < MAX_LENGTH) begin
        win_sum = win_sum - 42'(window_mem[win_head[IDX_W-1:0]]);
        win_head = win_head + 1'b1;
      end
      if (win_sum == 42'(target_q)) begin
        res.found = 1'b1;
        res.start_index = win_head;
        res.end_index = end_idx[END_W-1:0];
        predicted_results.push_back(res);
        seq_matched = 1'b1;
      end
    end
    // The last element closes the sequence; a sequence with no match reports so.
    if (is_last) begin
      if (!seq_matched) begin
        res = '0;
        predicted_results.push_back(res);
      end
      win_sum = '0;
      win_head = '0;
      seq_len = '0;
      seq_matched = 1'b0;
    end
  endfunction

  // Track requests on all three channels and check each result as it leaves.
  always @(posedge clk) begin : monitor
    search_result_t got;
    search_result_t want;
    if (!rst_n) begin
      win_sum = '0;
      win_head = '0;
      seq_len = '0;
      seq_matched = 1'b0;
      target_q = '0;
      predicted_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        target_q = cfg_target_sum;
      end
      if (in_valid && in_ready) begin
        advance_window(in_element, in_last);
      end
      if (out_valid && out_ready) begin
        got = {out_found, out_start_index, out_end_index};
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with none predicted: found=%0b start=%0d end=%0d",
                     $realtime, got.found, got.start_index, got.end_index);
          end
        end else begin
          want = predicted_results.pop_front();
          if (got.found !== want.found || got.start_index !== want.start_index ||
              got.end_index !== want.end_index) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch (found/start/end): expected %0b/%0d/%0d, got %0b/%0d/%0d",
                       $realtime, want.found, want.start_index, want.end_index,
                       got.found, got.start_index, got.end_index);
            end
          end
        end
      end
    end
    pending <= predicted_results.size();
    fail_count <= mismatches;
  end

endmodule

### dv/tb_subarray_with_target_sum_core.sv
`timescale 1ns / 100ps

module tb_subarray_with_target_sum_core;
  import swts_pkg::*;

  localparam int MAX_LEN        = MAX_LENGTH_DEF;
  // A single element may pop the whole window.
  localparam int DRAIN_CYCLES   = 2 * MAX_LEN + 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4 * (DRAIN_CYCLES + HOLD_CYCLES);
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 75;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;

  // Element distributions used by the random phases.
  typedef enum int {
    EL_SMALL_POS,
    EL_SMALL_MIX,
    EL_HALF_POS,
    EL_HALF_NEG
  } elem_mode_t;

  logic clk;
  logic rst_n;
  bit   calm;
  bit   hold_out;
  int   pending;
  int   fail_count;
  int   idle_cycles;

  swts_in_if  in_ch ();
  swts_out_if out_ch ();
  swts_cfg_if cfg_ch ();

  subarray_with_target_sum_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  swts_search_checker #(
    .MAX_LENGTH (MAX_LEN)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_element      (in_ch.element),
    .in_last         (in_ch.last),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_found       (out_ch.found),
    .out_start_index (out_ch.start_index),
    .out_end_index   (out_ch.end_index),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_target_sum  (cfg_ch.target_sum),
    .pending         (pending),
    .fail_count      (fail_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offers one element request after a random gap and returns once it is taken.
  task automatic send_element(input logic signed [ELEM_W-1:0] value, input bit is_last);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.element <= value;
    in_ch.last <= is_last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Lets the block run dry, then writes a new target.
  task automatic set_target(input logic signed [ELEM_W-1:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.target_sum <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [ELEM_W-1:0] draw_element(input elem_mode_t mode);
    logic signed [ELEM_W-1:0] value;
    // A tenth of the elements are full-range noise.
    if ($urandom_range(99) < 10) begin
      value = $urandom();
    end else begin
      case (mode)
        EL_SMALL_POS: value = int'($urandom_range(12));
        EL_SMALL_MIX: value = int'($urandom_range(12)) - 6;
        EL_HALF_POS: begin
          case ($urandom_range(3))
            0:       value = 32'sh3FFF_FFFF;
            1:       value = 32'sh4000_0000;
            default: value = int'($urandom_range(2)) - 1;
          endcase
        end
        default: begin
          case ($urandom_range(3))
            0:       value = 32'shC000_0000;
            1:       value = 32'shBFFF_FFFF;
            default: value = int'($urandom_range(2)) - 1;
          endcase
        end
      endcase
    end
    return value;
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = calm ? 0 : $urandom_range(4);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Watchdog: ends the run when no channel has moved a request for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_subarray_with_target_sum_core failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed cases, one overlong sequence, then random phases.
  initial begin
    int                       sent;
    int                       len;
    logic signed [ELEM_W-1:0] tgt;
    elem_mode_t               mode;
    rst_n <= 1'b0;
    calm = 1'b0;
    hold_out = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.element <= '0;
    in_ch.last <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.target_sum <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The target comes out of reset as zero: a lone zero matches at once.
    send_element(0, 1'b1);

    // A match mid-sequence, then ignored elements up to the last one.
    set_target(5);
    send_element(2, 1'b0);
    send_element(3, 1'b0);
    send_element(7, 1'b0);
    send_element(1, 1'b1);
    // No match by the last element.
    send_element(10, 1'b1);
    send_element(1, 1'b0);
    send_element(1, 1'b1);

    // Zero target: the window empties and the match reports start past end.
    set_target(0);
    send_element(4, 1'b0);
    send_element(-3, 1'b1);
    send_element(4, 1'b1);

    // Extreme targets and elements.
    set_target(ELEM_MAX);
    send_element(ELEM_MAX, 1'b1);
    send_element(ELEM_MIN, 1'b0);
    send_element(ELEM_MAX, 1'b1);
    set_target(ELEM_MIN);
    send_element(ELEM_MAX, 1'b0);
    send_element(ELEM_MIN, 1'b1);

    // Overlong sequence: elements past the buffer are dropped, no match.
    set_target(0);
    for (int i = 0; i < MAX_LEN; i++) begin
      send_element(-1, 1'b0);
    end
    send_element(5, 1'b0);
    send_element(-7, 1'b0);
    send_element(9, 1'b1);

    // Random phases, each with its own target and element mix.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          tgt = 0;
          mode = EL_SMALL_MIX;
        end
        1: begin
          tgt = int'($urandom_range(1, 40));
          mode = EL_SMALL_POS;
        end
        2: begin
          tgt = ELEM_MAX;
          mode = EL_HALF_POS;
        end
        3: begin
          tgt = ELEM_MIN;
          mode = EL_HALF_NEG;
        end
        4: begin
          tgt = -int'($urandom_range(1, 40));
          mode = EL_SMALL_MIX;
        end
        5: begin
          tgt = int'($urandom_range(40));
          mode = EL_SMALL_POS;
        end
        6: begin
          tgt = $urandom();
          mode = EL_SMALL_MIX;
        end
        default: begin
          tgt = int'($urandom_range(40)) - 20;
          mode = EL_SMALL_MIX;
        end
      endcase
      set_target(tgt);
      calm = (ph == 2) || (ph == 5);
      // Stall the result side for a while so the block backs up its input.
      if (ph == 1) begin
        hold_out = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_element(draw_element(mode), i == len - 1);
        end
        sent += len;
      end
    end

    // Drain and report.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_subarray_with_target_sum_core passed");
    end else begin
      $display("tb_subarray_with_target_sum_core failed");
    end
    $finish;
  end

endmodule

### files.f
design/swts_pkg.sv
design/swts_ifs.sv
design/swts_ctrl.sv
design/swts_dp.sv
design/subarray_with_target_sum_core.sv
dv/swts_search_checker.sv
dv/tb_subarray_with_target_sum_core.sv
